>>> hw/rtl/chained_hash_map_engine_unit_assert.svh
// ------------------------------------------------------------------------
// assertion macros for the chained hash map engine
// clocked forms used by the engine unit to check its own logic
// ------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ENGINE_UNIT_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_UNIT_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define CHM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent at the next clock edge
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/chm_pkg.sv
// ------------------------------------------------------------------------
// chm_pkg
// shared constants, codes and types of the chained hash map engine
// ------------------------------------------------------------------------
package chm_pkg;

    // default sizes
    localparam int CHM_BUCKETS     = 1024;
    localparam int CHM_NODES       = 4096;
    localparam int CHM_VALUE_WIDTH = 64;

    // configuration port
    localparam int CHM_ADDR_W = 5;
    localparam logic [1:0] CFG_MULT   = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_PRIME  = 2'd2;
    localparam logic [1:0] CFG_BCOUNT = 2'd3;

    // request codes
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_SET    = 3'd3;
    localparam logic [2:0] REQ_RESET  = 3'd4;

    // status codes
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_NEW      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // hash settings handed to the hash unit
    typedef struct packed {
        logic [63:0] mult;
        logic [63:0] offset;
        logic [63:0] prime;
        logic [63:0] nbk;
    } chm_hash_cfg_t;

endpackage

>>> hw/rtl/chm_req_if.sv
// ------------------------------------------------------------------------
// chm_req_if
// request channel: valid/ready with request type, key and value
// ------------------------------------------------------------------------
interface chm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] key;
    logic [63:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

>>> hw/rtl/chm_rsp_if.sv
// ------------------------------------------------------------------------
// chm_rsp_if
// result channel: valid/ready with status and read value
// ------------------------------------------------------------------------
interface chm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink (input valid, input status, input read_value, output ready);
endinterface

>>> hw/rtl/chm_ram.sv
// ------------------------------------------------------------------------
// chm_ram
// generic single write, single read ram with registered read data
// ------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/chm_hash.sv
// ------------------------------------------------------------------------
// chm_hash
// bucket hash: stepped 64-bit multiply, offset, then two remainders
// through one shared compare and subtract unit, one bit per cycle
// ------------------------------------------------------------------------
module chm_hash import chm_pkg::*; #(
    parameter int BUCKETS = CHM_BUCKETS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [63:0]                                 key,
    input  chm_hash_cfg_t                               cfg,
    output logic                                        done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_MUL  = 3'd1;
    localparam logic [2:0] H_OFF  = 3'd2;
    localparam logic [2:0] H_DIV1 = 3'd3;
    localparam logic [2:0] H_DIV2 = 3'd4;

    logic [2:0]    ph_reg, ph_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [63:0]   acc_reg, acc_next;
    logic [63:0]   prod_reg, prod_next;
    logic [63:0]   rem_reg, rem_next;
    logic [63:0]   key_reg, key_next;
    logic          done_reg, done_next;
    logic [BW-1:0] bucket_reg, bucket_next;

    logic [31:0] mul_a, mul_b;
    logic [64:0] trial, diff, divisor;
    logic [63:0] rem_step;

    // multiplier operand select per partial product
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                mul_a = cfg.mult[31:0];
                mul_b = key_reg[31:0];
            end
            2'd1:
            begin
                mul_a = cfg.mult[31:0];
                mul_b = key_reg[63:32];
            end
            2'd2:
            begin
                mul_a = cfg.mult[63:32];
                mul_b = key_reg[31:0];
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // shared compare and subtract for restoring remainder
    always_comb
    begin
        divisor  = (ph_reg == H_DIV1) ? {1'b0, cfg.prime} : {1'b0, cfg.nbk};
        trial    = {rem_reg, acc_reg[63]};
        diff     = trial - divisor;
        rem_step = (trial >= divisor) ? diff[63:0] : trial[63:0];
    end

    // sequencer
    always_comb
    begin
        ph_next     = ph_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        bucket_next = bucket_reg;
        case (ph_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    cnt_next = 6'd0;
                    ph_next  = H_MUL;
                end
            end
            H_MUL:
            begin
                prod_next = {32'd0, mul_a} * {32'd0, mul_b};
                cnt_next  = cnt_reg + 6'd1;
                case (cnt_reg[1:0])
                    2'd0: acc_next = acc_reg;
                    2'd1: acc_next = prod_reg;
                    default: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                endcase
                if (cnt_reg[1:0] == 2'd3)
                begin
                    ph_next = H_OFF;
                end
            end
            H_OFF:
            begin
                acc_next = acc_reg + cfg.offset;
                rem_next = 64'd0;
                cnt_next = 6'd0;
                // a zero prime skips the first remainder
                ph_next  = (cfg.prime == 64'd0) ? H_DIV2 : H_DIV1;
            end
            H_DIV1:
            begin
                rem_next = rem_step;
                acc_next = {acc_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    acc_next = rem_step;
                    rem_next = 64'd0;
                    cnt_next = 6'd0;
                    ph_next  = H_DIV2;
                end
            end
            H_DIV2:
            begin
                rem_next = rem_step;
                acc_next = {acc_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    bucket_next = rem_step[BW-1:0];
                    done_next   = 1'b1;
                    ph_next     = H_IDLE;
                end
            end
            default:
            begin
                ph_next = H_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= H_IDLE;
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        key_reg    <= key_next;
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

>>> hw/rtl/chained_hash_map_engine_unit.sv
// ------------------------------------------------------------------------
// chained_hash_map_engine_unit
// key/value map with separate chaining over a bounded node pool
// ------------------------------------------------------------------------
// usage: requests arrive on in_ch (valid/ready), one result per request
// leaves on out_ch from an output register; the user writes hash settings
// over the apb port while the block is idle; the block does not enforce it.
// after reset a clearing pass empties the bucket heads and live flags and
// fills the free stack with every node index; in_ch.ready stays low meanwhile.
// insert, remove, lookup and set: hashing (four multiply steps, offset,
// two bit-serial remainders in the shared subtract unit), the head read,
// a compare per chain node visited, the update, then the result hand-off.
// reset all: one live flag read per cycle.
// unknown request codes: status not found.
// one request is in flight at a time; the next is taken while the
// previous result waits; a stalled receiver holds the block in its final
// step until the output register frees.
// ------------------------------------------------------------------------
`include "chained_hash_map_engine_unit_assert.svh"

module chained_hash_map_engine_unit import chm_pkg::*; #(
    parameter int BUCKETS     = CHM_BUCKETS,
    parameter int NODES       = CHM_NODES,
    parameter int VALUE_WIDTH = CHM_VALUE_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CHM_ADDR_W-1:0] paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    chm_req_if.sink               in_ch,
    chm_rsp_if.source             out_ch
);

    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW   = $clog2(NODES + 1);
    localparam int MAXD = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int VW   = VALUE_WIDTH;
    localparam logic [PW-1:0] NIL = PW'(NODES);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_HEADW = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_ALOC  = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;
    localparam logic [3:0] S_REM1  = 4'd9;
    localparam logic [3:0] S_REM2  = 4'd10;
    localparam logic [3:0] S_SWP   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // configuration registers
    logic [63:0] mult_reg, offs_reg, prime_reg;
    logic [10:0] bc_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg  <= 64'd1;
            offs_reg  <= 64'd0;
            prime_reg <= 64'd1031;
            bc_reg    <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (paddr[4:3])
                CFG_MULT:   mult_reg  <= pwdata;
                CFG_OFFSET: offs_reg  <= pwdata;
                CFG_PRIME:  prime_reg <= pwdata;
                CFG_BCOUNT: bc_reg    <= pwdata[10:0];
                default:    mult_reg  <= mult_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            CFG_MULT:   prdata = mult_reg;
            CFG_OFFSET: prdata = offs_reg;
            CFG_PRIME:  prdata = prime_reg;
            CFG_BCOUNT: prdata = {53'd0, bc_reg};
            default:    prdata = 64'd0;
        endcase
    end

    // hash unit with saturated bucket count
    chm_hash_cfg_t hcfg;
    logic          h_start, h_done;
    logic [BW-1:0] h_bucket;
    logic [63:0]   key_reg, key_next;

    always_comb
    begin
        hcfg.mult   = mult_reg;
        hcfg.offset = offs_reg;
        hcfg.prime  = prime_reg;
        if (bc_reg == 11'd0)
        begin
            hcfg.nbk = 64'd1;
        end
        else if ({53'd0, bc_reg} > 64'(BUCKETS))
        begin
            hcfg.nbk = 64'(BUCKETS);
        end
        else
        begin
            hcfg.nbk = {53'd0, bc_reg};
        end
    end

    chm_hash #(.BUCKETS(BUCKETS)) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (h_start),
        .key    (key_reg),
        .cfg    (hcfg),
        .done   (h_done),
        .bucket (h_bucket)
    );

    // sequencer registers
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [2:0]    req_reg, req_next;
    logic [VW-1:0] val_reg, val_next;
    logic [BW-1:0] b_reg, b_next;
    logic [PW-1:0] e_reg, e_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] nxt_reg, nxt_next;
    logic [NW:0]   fc_reg, fc_next;
    logic [NW:0]   sw_reg, sw_next;
    logic          swv_reg, swv_next;
    logic [NW-1:0] swi_reg, swi_next;
    logic [1:0]    st_reg, st_next;
    logic [VW-1:0] rd_reg, rd_next;
    logic          ov_reg, ov_next;
    logic [1:0]    ost_reg, ost_next;
    logic [VW-1:0] ord_reg, ord_next;

    // memory ports
    logic          head_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [PW-1:0] head_wdata, head_rdata;
    logic          key_we;
    logic [NW-1:0] key_waddr, node_raddr;
    logic [63:0]   key_rdata;
    logic          val_we;
    logic [NW-1:0] val_waddr;
    logic [VW-1:0] val_wdata, val_rdata;
    logic          next_we;
    logic [NW-1:0] next_waddr;
    logic [PW-1:0] next_wdata, next_rdata;
    logic          live_we;
    logic [NW-1:0] live_waddr, live_raddr;
    logic [0:0]    live_wdata, live_rdata;
    logic          free_we;
    logic [NW-1:0] free_waddr, free_raddr;
    logic [NW-1:0] free_wdata, free_rdata;
    logic [NW:0]   fc_dec;

    assign fc_dec = fc_reg - 1'b1;

    chm_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    chm_ram #(.WIDTH(64), .DEPTH(NODES)) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_reg),
        .raddr(node_raddr), .rdata(key_rdata)
    );
    chm_ram #(.WIDTH(VW), .DEPTH(NODES)) u_value (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(node_raddr), .rdata(val_rdata)
    );
    chm_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(node_raddr), .rdata(next_rdata)
    );
    chm_ram #(.WIDTH(1), .DEPTH(NODES)) u_live (
        .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
        .raddr(live_raddr), .rdata(live_rdata)
    );
    chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = ov_reg;
    assign out_ch.status     = ost_reg;
    assign out_ch.read_value = 64'(ord_reg);

    // main sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        req_next   = req_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        prev_next  = prev_reg;
        nxt_next   = nxt_reg;
        fc_next    = fc_reg;
        sw_next    = sw_reg;
        swv_next   = 1'b0;
        swi_next   = sw_reg[NW-1:0];
        st_next    = st_reg;
        rd_next    = rd_reg;
        ov_next    = ov_reg & ~out_ch.ready;
        ost_next   = ost_reg;
        ord_next   = ord_reg;
        h_start    = 1'b0;

        head_we    = 1'b0;
        head_waddr = b_reg;
        head_wdata = NIL;
        head_raddr = b_reg;
        key_we     = 1'b0;
        key_waddr  = e_reg[NW-1:0];
        node_raddr = e_reg[NW-1:0];
        val_we     = 1'b0;
        val_waddr  = e_reg[NW-1:0];
        val_wdata  = val_reg;
        next_we    = 1'b0;
        next_waddr = e_reg[NW-1:0];
        next_wdata = NIL;
        live_we    = 1'b0;
        live_waddr = e_reg[NW-1:0];
        live_wdata = 1'b0;
        live_raddr = sw_reg[NW-1:0];
        free_we    = 1'b0;
        free_waddr = fc_reg[NW-1:0];
        free_wdata = e_reg[NW-1:0];
        free_raddr = fc_dec[NW-1:0];

        case (state_reg)
            // clearing pass after reset
            S_CLR:
            begin
                head_we    = (clr_reg < BUCKETS);
                head_waddr = clr_reg[BW-1:0];
                live_we    = (clr_reg < NODES);
                live_waddr = clr_reg[NW-1:0];
                free_we    = (clr_reg < NODES);
                free_waddr = clr_reg[NW-1:0];
                free_wdata = clr_reg[NW-1:0];
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CW'(MAXD - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    req_next = in_ch.req_type;
                    key_next = in_ch.key;
                    val_next = in_ch.value[VW-1:0];
                    rd_next  = '0;
                    sw_next  = '0;
                    if (in_ch.req_type == REQ_RESET)
                    begin
                        state_next = S_SWP;
                    end
                    else if (in_ch.req_type inside {REQ_INSERT, REQ_REMOVE,
                                                    REQ_LOOKUP, REQ_SET})
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
            end
            S_HASH:
            begin
                h_start = (req_reg != REQ_RESET) & ~h_done;
                if (h_done)
                begin
                    b_next     = h_bucket;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_HEADW;
            end
            S_HEADW:
            begin
                e_next     = head_rdata;
                prev_next  = NIL;
                state_next = S_CHK;
            end
            // end of chain or read the node
            S_CHK:
            begin
                if (e_reg >= NIL)
                begin
                    if (req_reg == REQ_INSERT)
                    begin
                        if (fc_reg == '0)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ALOC;
                        end
                    end
                    else
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                nxt_next = next_rdata;
                if (key_rdata == key_reg)
                begin
                    st_next    = ST_HIT;
                    state_next = S_DONE;
                    case (req_reg)
                        REQ_INSERT, REQ_SET: val_we = 1'b1;
                        REQ_LOOKUP: rd_next = val_rdata;
                        REQ_REMOVE: state_next = S_REM1;
                        default: st_next = ST_HIT;
                    endcase
                end
                else
                begin
                    prev_next  = e_reg;
                    e_next     = next_rdata;
                    state_next = S_CHK;
                end
            end
            // take a node from the free stack and append it
            S_ALOC:
            begin
                fc_next    = fc_dec;
                key_we     = 1'b1;
                key_waddr  = free_rdata;
                val_we     = 1'b1;
                val_waddr  = free_rdata;
                live_we    = 1'b1;
                live_waddr = free_rdata;
                live_wdata = 1'b1;
                next_we    = 1'b1;
                next_waddr = free_rdata;
                st_next    = ST_NEW;
                e_next     = PW'(free_rdata);
                if (prev_reg == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = PW'(free_rdata);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                next_we    = 1'b1;
                next_waddr = prev_reg[NW-1:0];
                next_wdata = e_reg;
                state_next = S_DONE;
            end
            // unlink and free the node
            S_REM1:
            begin
                if (prev_reg == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = nxt_reg;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_reg[NW-1:0];
                    next_wdata = nxt_reg;
                end
                live_we = 1'b1;
                if (fc_reg < NODES)
                begin
                    free_we = 1'b1;
                    fc_next = fc_reg + 1'b1;
                end
                state_next = S_REM2;
            end
            S_REM2:
            begin
                next_we    = 1'b1;
                state_next = S_DONE;
            end
            // write the value into every live node
            S_SWP:
            begin
                val_we    = swv_reg & live_rdata[0];
                val_waddr = swi_reg;
                swv_next  = (sw_reg < NODES);
                if (sw_reg < NODES)
                begin
                    sw_next = sw_reg + 1'b1;
                end
                else
                begin
                    st_next    = ST_HIT;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    ord_next   = rd_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            fc_reg    <= (NW + 1)'(NODES);
            sw_reg    <= '0;
            swv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fc_reg    <= fc_next;
            sw_reg    <= sw_next;
            swv_reg   <= swv_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        b_reg    <= b_next;
        e_reg    <= e_next;
        prev_reg <= prev_next;
        nxt_reg  <= nxt_next;
        swi_reg  <= swi_next;
        st_reg   <= st_next;
        rd_reg   <= rd_next;
        ost_reg  <= ost_next;
        ord_reg  <= ord_next;
    end

    // checks
    `CHM_ASSERT_ALWAYS(a_fc_bound, fc_reg <= (NW + 1)'(NODES), "free count above pool size")
    `CHM_ASSERT_ALWAYS(a_clr_blocks, (state_reg == S_CLR) |-> !in_ch.ready,
        "request taken during clearing pass")
    `CHM_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, state_reg != S_IDLE,
        "accepted transaction left block idle")
    `CHM_ASSERT_NEXT(a_done_loads, (state_reg == S_DONE) && (!ov_reg || out_ch.ready),
        ov_reg && (state_reg == S_IDLE), "result not loaded into output register")

endmodule
